// File: src/arm_pkg.sv
// Shared constants, types and state codes for the audio RMS level meter.
`timescale 1ns / 1ps

package arm_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 15;
  localparam int GAIN_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Buffer length limit, in stereo frames
  localparam int MAX_FRAMES = 256;
  localparam int CNT_MAX    = 2 * MAX_FRAMES;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);

  // Accumulator and squares
  localparam int SQ_W  = 2 * SAMPLE_W - 1;
  localparam int SUM_W = 38;
  localparam logic [SUM_W:0] SUM_MAX = {1'b0, {SUM_W{1'b1}}};

  // Divider: divisor is four times the sample count
  localparam int DVS_W  = CNT_W + 2;
  localparam int STEP_W = $clog2(SUM_W);

  // Square root: two radicand bits per step
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int TRIAL_W    = ROOT_W + 4;

  // Smoothing arithmetic
  localparam int KEEP_W    = GAIN_W + 1;
  localparam int PROD_W    = LEVEL_W + KEEP_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam logic [KEEP_W-1:0] GAIN_ONE = KEEP_W'(1 << GAIN_W);
  localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1 << (GAIN_W - 1));

  // Full-scale level, 1.0 in Q1.14 of halved samples
  localparam logic [LEVEL_W-1:0] LEVEL_FULL_SCALE = LEVEL_W'(16384);

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_GAIN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOUD_THRESHOLD = CFG_IDX_W'(1);

  // Configuration reset values
  localparam logic [GAIN_W-1:0]  GAIN_RESET      = GAIN_W'(4588);
  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = LEVEL_W'(1311);

  // Queue entry: both squares of one frame and its end-of-buffer mark
  typedef struct packed {
    logic [SQ_W-1:0] sq_left;
    logic [SQ_W-1:0] sq_right;
    logic            last_frame;
  } sq_entry_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_ADD
  } arm_state_e;

endpackage

// File: src/arm_frame_if.sv
// Input channel carrying one stereo frame per transaction.
`timescale 1ns / 1ps

interface arm_frame_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               last_frame;

  modport source (output valid, left_sample, right_sample, last_frame, input ready);
  modport sink   (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

// File: src/arm_level_if.sv
// Output channel carrying one level result per transaction.
`timescale 1ns / 1ps

interface arm_level_if;
  logic        valid;
  logic        ready;
  logic [14:0] rms_level;
  logic [14:0] smoothed_level;
  logic        loud;

  modport source (output valid, rms_level, smoothed_level, loud, input ready);
  modport sink   (input valid, rms_level, smoothed_level, loud, output ready);
endinterface

// File: src/audio_rms_level_meter_core.sv
// Top level of the audio RMS level meter: config registers, front, queue, back.
//
//  channel     dir  payload                                    transaction when
//  frame_if    in   left_sample, right_sample, last_frame      valid & ready
//  level_if    out  rms_level, smoothed_level, loud            valid & ready
//  cfg_*       in   cfg_idx_i, cfg_data_i                      cfg_we_i
//
// A frame that does not end a buffer is accumulated in the back end; the
// squares are formed one stage earlier in the front end.
// A buffer end then runs the bit-serial divider, the square root unit, and
// the smoothing multiply and add.
// The 4-entry queue keeps taking frames while the back end divides.
// A finished result waits in the output register; the back end stalls only
// when a second result is ready before the first is taken.
// Reset clears the sum, the count, the smoothed level and all valid flags.
`timescale 1ns / 1ps

module audio_rms_level_meter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [arm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [arm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  arm_frame_if.sink                          frame_if,
  arm_level_if.source                        level_if
);
  import arm_pkg::*;

  logic [GAIN_W-1:0]     gain_q;
  logic [LEVEL_W-1:0]    thr_q;
  logic                  push_valid;
  logic                  push_ready;
  sq_entry_t             push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  sq_entry_t             pop_data;
  logic [FIFO_LVL_W-1:0] fifo_level;
  logic [CNT_W-1:0]      acc_count;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      thr_q  <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SMOOTH_GAIN:    gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_LOUD_THRESHOLD: thr_q  <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  arm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_if     (frame_if),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  arm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data),
    .level_o      (fifo_level)
  );

  arm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .gain_i      (gain_q),
    .thr_i       (thr_q),
    .level_if    (level_if),
    .acc_count_o (acc_count)
  );

  // Levels stay within full scale
  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_if.valid |-> level_if.rms_level <= LEVEL_FULL_SCALE)
    else $error("rms level above full scale");

  a_smooth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_if.valid |-> level_if.smoothed_level <= LEVEL_FULL_SCALE)
    else $error("smoothed level above full scale");

  // Queue never overfills
  a_fifo_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_level <= FIFO_LVL_W'(FIFO_DEPTH))
    else $error("queue level above depth");

  // Sample count saturates at the buffer limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_count <= CNT_W'(CNT_MAX))
    else $error("sample count above limit");

endmodule

// File: src/arm_front.sv
// Front end: takes frames, squares both samples and queues them.
`timescale 1ns / 1ps

module arm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  arm_frame_if.sink         frame_if,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output arm_pkg::sq_entry_t push_data_o
);
  import arm_pkg::*;

  logic                       vld_q;
  logic signed [SAMPLE_W-1:0] left_q;
  logic signed [SAMPLE_W-1:0] right_q;
  logic                       last_q;
  logic signed [2*SAMPLE_W-1:0] sq_left;
  logic signed [2*SAMPLE_W-1:0] sq_right;
  logic                       take;

  // Stage register frees up as soon as the queue takes its content
  assign frame_if.ready = !vld_q || push_ready_i;
  assign take           = frame_if.valid && frame_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (frame_if.ready) begin
      vld_q <= frame_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      left_q  <= frame_if.left_sample;
      right_q <= frame_if.right_sample;
      last_q  <= frame_if.last_frame;
    end
  end

  // Squares are never negative; the top bit of the product is always zero
  assign sq_left  = left_q * left_q;
  assign sq_right = right_q * right_q;

  assign push_valid_o           = vld_q;
  assign push_data_o.sq_left    = sq_left[SQ_W-1:0];
  assign push_data_o.sq_right   = sq_right[SQ_W-1:0];
  assign push_data_o.last_frame = last_q;

endmodule

// File: src/arm_fifo.sv
// Short queue of squared frames between front and back end.
`timescale 1ns / 1ps

module arm_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_valid_i,
  output logic                             push_ready_o,
  input  arm_pkg::sq_entry_t               push_data_i,
  output logic                             pop_valid_o,
  input  logic                             pop_ready_i,
  output arm_pkg::sq_entry_t               pop_data_o,
  output logic [arm_pkg::FIFO_LVL_W-1:0]   level_o
);
  import arm_pkg::*;

  sq_entry_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_LVL_W-1:0] level_q;
  logic                  push;
  logic                  pop;

  assign push_ready_o = (level_q != FIFO_LVL_W'(FIFO_DEPTH));
  assign pop_valid_o  = (level_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem[rd_ptr_q];
  assign level_o      = level_q;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      if (push && !pop)      level_q <= level_q + FIFO_LVL_W'(1);
      else if (pop && !push) level_q <= level_q - FIFO_LVL_W'(1);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) mem[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: src/arm_back.sv
// Back end: accumulates squares, then divides, takes the root and smooths.
`timescale 1ns / 1ps

module arm_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  arm_pkg::sq_entry_t             pop_data_i,
  input  logic [arm_pkg::GAIN_W-1:0]     gain_i,
  input  logic [arm_pkg::LEVEL_W-1:0]    thr_i,
  arm_level_if.source                    level_if,
  output logic [arm_pkg::CNT_W-1:0]      acc_count_o
);
  import arm_pkg::*;

  arm_state_e state_q, state_d;

  // Running accumulation
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] cnt_new;
  logic             pop;

  // Shared shift register: dividend/quotient, then radicand
  logic [SUM_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;
  logic [DVS_W:0]    rem_sh;
  logic              q_bit;

  // Square root
  logic [ROOT_W-1:0]  root_q;
  logic [SREM_W-1:0]  srem_q;
  logic [TRIAL_W-1:0] srem_sh;
  logic [TRIAL_W-1:0] trial;
  logic               r_bit;

  // Smoothing
  logic [LEVEL_W-1:0] smoothed_q;
  logic [LEVEL_W-1:0] rms_q;
  logic [KEEP_W-1:0]  keep;
  logic [PROD_W-1:0]  prod_old_q;
  logic [PROD_W-1:0]  prod_new_q;
  logic [ACC_W-1:0]   acc;
  logic [LEVEL_W-1:0] smooth_d;

  // Output register
  logic               out_vld_q;
  logic [LEVEL_W-1:0] out_rms_q;
  logic [LEVEL_W-1:0] out_smooth_q;
  logic               out_loud_q;
  logic               out_load;

  assign pop = pop_valid_i && pop_ready_o;

  // Saturating add of both squares; samples past the limit are dropped
  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(pop_data_i.sq_left)
                 + (SUM_W+1)'(pop_data_i.sq_right);
  always_comb begin
    if (cnt_q < CNT_W'(CNT_MAX)) begin
      sum_new = (sum_add > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_add[SUM_W-1:0];
      cnt_new = cnt_q + CNT_W'(2);
    end else begin
      sum_new = sum_q;
      cnt_new = cnt_q;
    end
  end

  // Restoring division step
  assign rem_sh = {rem_q, dvd_q[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs_q});

  // Square root step: two radicand bits in, one root bit out
  assign srem_sh = {srem_q, dvd_q[SUM_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign r_bit   = (srem_sh >= trial);

  // Exponential average with round half up
  assign keep     = GAIN_ONE - KEEP_W'(gain_i);
  assign acc      = ACC_W'(prod_old_q) + ACC_W'(prod_new_q) + ROUND_HALF;
  assign smooth_d = acc[GAIN_W +: LEVEL_W];

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshakes
  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_ACC: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i && pop_data_i.last_frame) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (step_q == '0) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (step_q == '0) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (!out_vld_q || level_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  // Architectural state: sum, count, smoothed level, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      cnt_q      <= '0;
      smoothed_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (pop) begin
        if (pop_data_i.last_frame) begin
          sum_q <= '0;
          cnt_q <= '0;
        end else begin
          sum_q <= sum_new;
          cnt_q <= cnt_new;
        end
      end
      if (out_load) begin
        smoothed_q <= smooth_d;
        out_vld_q  <= 1'b1;
      end else if (level_if.ready) begin
        out_vld_q  <= 1'b0;
      end
    end
  end

  // Arithmetic datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_ACC: begin
        if (pop && pop_data_i.last_frame) begin
          dvd_q  <= sum_new;
          dvs_q  <= {cnt_new, 2'b00};
          rem_q  <= '0;
          step_q <= STEP_W'(SUM_W - 1);
        end
      end
      ST_DIV: begin
        dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
        rem_q <= q_bit ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
        if (step_q == '0) begin
          step_q <= STEP_W'(SQRT_STEPS - 1);
          root_q <= '0;
          srem_q <= '0;
        end else begin
          step_q <= step_q - STEP_W'(1);
        end
      end
      ST_SQRT: begin
        dvd_q  <= {dvd_q[SUM_W-3:0], 2'b00};
        root_q <= {root_q[ROOT_W-2:0], r_bit};
        srem_q <= r_bit ? SREM_W'(srem_sh - trial) : srem_sh[SREM_W-1:0];
        step_q <= step_q - STEP_W'(1);
      end
      ST_MUL: begin
        rms_q      <= root_q[LEVEL_W-1:0];
        prod_old_q <= PROD_W'(smoothed_q) * PROD_W'(keep);
        prod_new_q <= PROD_W'(gain_i) * PROD_W'(root_q[LEVEL_W-1:0]);
      end
      ST_ADD: begin
        if (out_load) begin
          out_rms_q    <= rms_q;
          out_smooth_q <= smooth_d;
          out_loud_q   <= (rms_q >= thr_i);
        end
      end
      default: ;
    endcase
  end

  assign level_if.valid          = out_vld_q;
  assign level_if.rms_level      = out_rms_q;
  assign level_if.smoothed_level = out_smooth_q;
  assign level_if.loud           = out_loud_q;
  assign acc_count_o             = cnt_q;

endmodule

// File: bench/tb_audio_rms_level_meter_core.sv
// Self-checking testbench for the audio RMS level meter core: directed and random frames.
`timescale 1ns / 1ps

module tb_audio_rms_level_meter_core;
  import arm_pkg::*;

  localparam int  HALF_PERIOD   = 4;
  localparam int  RESET_CYCLES  = 10;
  // Margin for the back end to finish a buffer end
  localparam int  SETTLE_CYCLES = 120;
  localparam time RUN_LIMIT     = 5ms;

  // One expected result transaction
  typedef struct {
    logic [LEVEL_W-1:0] rms_level;
    logic [LEVEL_W-1:0] smoothed_level;
    logic               loud;
  } level_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  arm_frame_if frame_bus ();
  arm_level_if level_bus ();

  audio_rms_level_meter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .frame_if   (frame_bus),
    .level_if   (level_bus)
  );

  // Meter state as the testbench sees it
  logic [GAIN_W-1:0]  gain_reg;
  logic [LEVEL_W-1:0] threshold_reg;
  logic [SUM_W-1:0]   energy_sum;
  logic [CNT_W-1:0]   samples_held;
  logic [LEVEL_W-1:0] smooth_reg;

  level_t levels_due[$];
  level_t level_head;
  int     mismatches;
  bit     idle_en;
  int     hold_cnt;

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Floor square root, one result bit at a time from the top
  function automatic logic [ROOT_W-1:0] root_floor(input logic [SUM_W-1:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= 64'(x)) root = trial;
    end
    return root[ROOT_W-1:0];
  endfunction

  // Add one square to the energy sum, saturating at the top of the range
  function automatic logic [SUM_W-1:0] add_energy(input logic [SUM_W-1:0] acc,
                                                  input logic signed [15:0] s);
    logic [SUM_W:0] wide;
    logic [31:0]    sq;
    sq   = 32'(int'(s) * int'(s));
    wide = {1'b0, acc} + (SUM_W + 1)'(sq);
    return (wide > SUM_MAX) ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
  endfunction

  // Advance the meter by one accepted frame; queue a level at buffer end
  task automatic update_meter(input logic signed [15:0] left, input logic signed [15:0] right,
                              input logic last_frame);
    logic [SUM_W-1:0]  mean_sq;
    logic [ROOT_W-1:0] rms;
    logic [63:0]       acc;
    level_t            lvl;
    // frames past the buffer limit do not count
    if (samples_held < CNT_MAX) begin
      energy_sum   = add_energy(energy_sum, left);
      energy_sum   = add_energy(energy_sum, right);
      samples_held = samples_held + CNT_W'(2);
    end
    if (last_frame) begin
      rms = '0;
      if (samples_held != 0) begin
        mean_sq = energy_sum / (SUM_W'(samples_held) * 4);
        rms     = root_floor(mean_sq);
      end
      acc = 64'(smooth_reg) * (64'd65536 - 64'(gain_reg)) + 64'(gain_reg) * 64'(rms) + 64'd32768;
      smooth_reg         = acc[16 +: LEVEL_W];
      lvl.rms_level      = rms[LEVEL_W-1:0];
      lvl.smoothed_level = smooth_reg;
      lvl.loud           = (32'(rms) >= 32'(threshold_reg));
      levels_due.push_back(lvl);
      energy_sum   = '0;
      samples_held = '0;
    end
  endtask

  // Send one frame; valid stays high on return so the next frame can follow
  task automatic send_frame(input logic signed [15:0] left, input logic signed [15:0] right,
                            input logic last_frame);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      frame_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    frame_bus.valid        <= 1'b1;
    frame_bus.left_sample  <= left;
    frame_bus.right_sample <= right;
    frame_bus.last_frame   <= last_frame;
    @(posedge clk_i);
    while (!frame_bus.ready) @(posedge clk_i);
    update_meter(left, right, last_frame);
  endtask

  // Stop sending and hold until every queued level has come out
  task automatic wait_idle();
    frame_bus.valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers; only called with the block idle
  task automatic set_config(input logic [GAIN_W-1:0] gain, input logic [LEVEL_W-1:0] threshold);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SMOOTH_GAIN;
    cfg_data_i <= CFG_DATA_W'(gain);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_LOUD_THRESHOLD;
    cfg_data_i <= CFG_DATA_W'(threshold);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gain_reg      = gain;
    threshold_reg = threshold;
  endtask

  // Sample mix: full range, quiet, moderate, rails and silence
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0, 1:    return 16'($urandom);
      2:       return 16'($signed(32'($urandom_range(0, 511)) - 256));
      3:       return 16'($signed(32'($urandom_range(0, 8191)) - 4096));
      4:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'sh0000;
    endcase
  endfunction

  // Reset values of the registers with single-frame buffers and one two-frame buffer
  task automatic test_reset_config();
    send_frame(16'sh0000, 16'sh0000, 1'b1);
    send_frame(16'sh7fff, 16'sh8000, 1'b1);
    send_frame(16'sh0400, -16'sh0400, 1'b0);
    send_frame(16'sh0300, 16'sh0100, 1'b1);
    wait_idle();
  endtask

  // Sample rails and smallest magnitudes
  task automatic test_sample_extremes();
    set_config(16'd32768, 15'd8192);
    send_frame(16'sh8000, 16'sh8000, 1'b1);
    send_frame(16'sh7fff, 16'sh7fff, 1'b1);
    send_frame(16'sh0001, 16'shffff, 1'b1);
    send_frame(16'shffff, 16'sh0001, 1'b0);
    send_frame(16'sh5555, 16'shaaaa, 1'b1);
    wait_idle();
  endtask

  // Gain and threshold at their extremes, including a threshold above full scale
  task automatic test_config_extremes();
    set_config(16'd0, 15'd0);
    send_frame(16'sh0000, 16'sh0000, 1'b1);
    send_frame(16'sh4000, 16'shc000, 1'b1);
    wait_idle();
    set_config(16'hffff, 15'd16384);
    send_frame(16'sh8000, 16'sh8000, 1'b1);
    send_frame(16'sh1234, 16'sh8765, 1'b1);
    wait_idle();
    set_config(16'd1, 15'd16385);
    send_frame(16'sh8000, 16'sh8000, 1'b1);
    wait_idle();
    set_config(16'd65534, 15'h7fff);
    send_frame(16'sh8000, 16'sh8000, 1'b1);
    send_frame(16'sh0000, 16'sh0000, 1'b1);
    wait_idle();
  endtask

  // Overlong buffers: a saturating sum and a sample count that stops at the limit
  task automatic test_long_buffers();
    set_config(GAIN_RESET, THRESHOLD_RESET);
    for (int i = 0; i < MAX_FRAMES + 8; i++)
      send_frame(16'sh8000, 16'sh8000, i == MAX_FRAMES + 7);
    for (int i = 0; i < MAX_FRAMES + 4; i++)
      send_frame(pick_sample(), pick_sample(), 1'b0);
    send_frame(16'sh7fff, 16'sh8000, 1'b1);
    wait_idle();
  endtask

  // Random buffers of random length, with occasional full drains
  task automatic test_random_phase(input int n_items, input bit idle,
                                   input logic [GAIN_W-1:0] gain,
                                   input logic [LEVEL_W-1:0] threshold);
    int sent;
    int len;
    set_config(gain, threshold);
    idle_en = idle;
    sent    = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) == 0) len = $urandom_range(MAX_FRAMES + 1, MAX_FRAMES + 40);
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(7, 40);
      else len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_frame(pick_sample(), pick_sample(), i == len - 1);
      sent += len;
      // sender holds off until the output side has caught up
      if ($urandom_range(0, 15) == 0) begin
        frame_bus.valid <= 1'b0;
        while (levels_due.size() != 0) @(posedge clk_i);
      end
    end
    wait_idle();
  endtask

  // Result checker and output-side stall generator
  always @(posedge clk_i) begin
    if (rst_ni && level_bus.valid && level_bus.ready) begin
      if (levels_due.size() == 0) begin
        $error("unexpected level transaction: rms_level %0d smoothed_level %0d loud %0d",
               level_bus.rms_level, level_bus.smoothed_level, level_bus.loud);
        mismatches++;
      end else begin
        level_head = levels_due.pop_front();
        if (level_bus.rms_level !== level_head.rms_level) begin
          $error("rms_level: expected %0d actual %0d", level_head.rms_level, level_bus.rms_level);
          mismatches++;
        end
        if (level_bus.smoothed_level !== level_head.smoothed_level) begin
          $error("smoothed_level: expected %0d actual %0d",
                 level_head.smoothed_level, level_bus.smoothed_level);
          mismatches++;
        end
        if (level_bus.loud !== level_head.loud) begin
          $error("loud: expected %0d actual %0d", level_head.loud, level_bus.loud);
          mismatches++;
        end
      end
    end
    if (!idle_en) begin
      hold_cnt        <= 0;
      level_bus.ready <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt        <= hold_cnt - 1;
      level_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      hold_cnt        <= $urandom_range(0, 3);
      level_bus.ready <= 1'b0;
    end else begin
      level_bus.ready <= 1'b1;
    end
  end

  // Hang guard
  initial begin
    #(RUN_LIMIT);
    $display("tb_audio_rms_level_meter_core failed");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CFG_SMOOTH_GAIN;
    cfg_data_i             = '0;
    frame_bus.valid        = 1'b0;
    frame_bus.left_sample  = '0;
    frame_bus.right_sample = '0;
    frame_bus.last_frame   = 1'b0;
    level_bus.ready        = 1'b0;
    hold_cnt               = 0;
    mismatches             = 0;
    idle_en                = 1'b1;
    gain_reg               = GAIN_RESET;
    threshold_reg          = THRESHOLD_RESET;
    energy_sum             = '0;
    samples_held           = '0;
    smooth_reg             = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_sample_extremes();
    test_config_extremes();
    test_long_buffers();
    test_random_phase(120, 1'b1, 16'($urandom), 15'($urandom_range(0, 16384)));
    test_random_phase(120, 1'b1, 16'd0, 15'd0);
    test_random_phase(120, 1'b1, 16'hffff, 15'd16384);
    test_random_phase(120, 1'b1, 16'($urandom), 15'h7fff);
    test_random_phase(120, 1'b1, 16'($urandom_range(1, 8192)), 15'($urandom_range(0, 4096)));
    test_random_phase(110, 1'b0, GAIN_RESET, THRESHOLD_RESET);

    if (mismatches == 0) begin
      $display("tb_audio_rms_level_meter_core passed");
    end else begin
      $display("tb_audio_rms_level_meter_core failed");
    end
    $finish;
  end

endmodule
